/* hw/rtl/btc_pkg.sv */
`default_nettype none

package btc_pkg;

  // Both queues share one depth.
  localparam int unsigned QAw = 2;
  localparam int unsigned QDepth = 1 << QAw;

  localparam int unsigned FrontStages = 7;
  localparam int unsigned PreStages = 8;
  localparam int unsigned DivSteps = 64;
  localparam int unsigned PostStages = 5;

  localparam logic [31:0] FineOffset = 32'd128000;
  localparam logic [20:0] RawFull = 21'd1048576;
  localparam logic [11:0] PressScale = 12'd3125;
  localparam logic [31:0] RoundHalf = 32'd128;
  localparam logic [31:0] MilliScale = 32'd1000;
  // Reciprocal of 100 scaled by 2^37; exact for every 32-bit dividend.
  localparam logic [31:0] Recip100 = 32'd1374389535;
  localparam logic [63:0] Q47One = 64'h0000_8000_0000_0000;

  typedef enum logic [1:0] {
    CfgTemp      = 2'd0,
    CfgPressLo   = 2'd1,
    CfgPressHi   = 2'd2,
    CfgPressNine = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [15:0] t1;
    logic [15:0] t2;
    logic [15:0] t3;
  } temp_cal_t;

  typedef struct packed {
    logic [15:0] p1;
    logic [15:0] p2;
    logic [15:0] p3;
    logic [15:0] p4;
    logic [15:0] p5;
    logic [15:0] p6;
    logic [15:0] p7;
    logic [15:0] p8;
    logic [15:0] p9;
  } press_cal_t;

  typedef struct packed {
    logic [19:0] raw_pressure;
    logic [31:0] milli;
    logic [31:0] fine;
  } temp_res_t;

  typedef struct packed {
    logic [23:0] pressure_pa;
    logic [31:0] milli;
    logic [31:0] fine;
    logic        divisor_zero;
  } result_t;

endpackage

`default_nettype wire

/* hw/rtl/btc_front.sv */
`default_nettype none

module btc_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  btc_pkg::temp_cal_t    cal_i,
  input  logic                  in_push_i,
  output logic                  in_full_o,
  input  logic [19:0]           raw_pressure_i,
  input  logic [19:0]           raw_temperature_i,
  input  logic                  q_full_i,
  output logic                  q_push_o,
  output btc_pkg::temp_res_t    q_item_o
);

  localparam int unsigned Last = btc_pkg::FrontStages - 1;

  logic [btc_pkg::FrontStages-1:0] vld_q;
  logic [19:0] pr_q [btc_pkg::FrontStages];
  logic adv;

  logic signed [17:0] a_q;
  logic signed [16:0] d_q;
  logic signed [33:0] ad_q, dd_q;
  logic signed [31:0] tv1_q;
  logic signed [47:0] xt_q;
  logic signed [31:0] fine4_q, fine5_q, fine6_q, fine7_q;
  logic [31:0] m_q;
  logic        neg_q;
  logic [63:0] rp_q;
  logic [31:0] milli_q;

  logic signed [31:0] x_w, tv2_w, hund_w;
  logic [31:0] f5_w, mag_w;
  logic [26:0] quo_w;

  assign adv       = !(vld_q[Last] && q_full_i);
  assign in_full_o = !adv;
  assign q_push_o  = vld_q[Last] && adv;
  assign q_item_o  = '{raw_pressure: pr_q[Last], milli: milli_q, fine: fine7_q};

  assign x_w    = $signed(dd_q[31:0]) >>> 12;
  assign tv2_w  = $signed(xt_q[31:0]) >>> 14;
  assign f5_w   = {fine4_q[29:0], 2'b00} + fine4_q + btc_pkg::RoundHalf;
  assign hund_w = $signed(f5_w) >>> 8;
  assign mag_w  = m_q[31] ? (32'd0 - m_q) : m_q;
  assign quo_w  = rp_q[63:37];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[Last-1:0], in_push_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pr_q[0] <= raw_pressure_i;
      for (int k = 1; k < btc_pkg::FrontStages; k++) begin
        pr_q[k] <= pr_q[k-1];
      end
      a_q <= $signed({1'b0, raw_temperature_i[19:3]}) - $signed({1'b0, cal_i.t1, 1'b0});
      d_q <= $signed({1'b0, raw_temperature_i[19:4]}) - $signed({1'b0, cal_i.t1});
      ad_q <= a_q * $signed(cal_i.t2);
      dd_q <= d_q * d_q;
      tv1_q <= $signed(ad_q[31:0]) >>> 11;
      xt_q <= x_w * $signed(cal_i.t3);
      fine4_q <= tv1_q + tv2_w;
      fine5_q <= fine4_q;
      m_q <= hund_w * btc_pkg::MilliScale;
      fine6_q <= fine5_q;
      neg_q <= m_q[31];
      rp_q <= mag_w * btc_pkg::Recip100;
      fine7_q <= fine6_q;
      milli_q <= neg_q ? (32'd0 - {5'd0, quo_w}) : {5'd0, quo_w};
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/btc_queue.sv */
`default_nettype none

module btc_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  output logic               full_o,
  input  btc_pkg::temp_res_t item_i,
  input  logic               pop_i,
  output logic               empty_o,
  output btc_pkg::temp_res_t item_o
);

  btc_pkg::temp_res_t mem_q [btc_pkg::QDepth];
  logic [btc_pkg::QAw-1:0] wptr_q, rptr_q;
  logic [btc_pkg::QAw:0]   cnt_q;
  logic do_push, do_pop;

  assign full_o  = cnt_q == (btc_pkg::QAw+1)'(btc_pkg::QDepth);
  assign empty_o = cnt_q == '0;
  assign item_o  = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) wptr_q <= wptr_q + 1'b1;
      if (do_pop) rptr_q <= rptr_q + 1'b1;
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wptr_q] <= item_i;
  end

endmodule

`default_nettype wire

/* hw/rtl/btc_back.sv */
`default_nettype none

module btc_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  btc_pkg::press_cal_t cal_i,
  input  logic                q_empty_i,
  input  btc_pkg::temp_res_t  q_item_i,
  output logic                q_pop_o,
  output logic                empty_o,
  input  logic                pop_i,
  output btc_pkg::result_t    res_o
);

  localparam int unsigned NPre = btc_pkg::PreStages;
  localparam int unsigned NDiv = btc_pkg::DivSteps;
  localparam int unsigned NPost = btc_pkg::PostStages;

  logic adv;
  logic [NPre-1:0]  pvld_q;
  logic [NDiv-1:0]  dvld_q;
  logic [NPost-1:0] qvld_q;
  btc_pkg::temp_res_t pit_q [NPre];
  btc_pkg::temp_res_t dit_q [NDiv];
  btc_pkg::temp_res_t qit_q [NPost];

  logic signed [32:0] v1_q;
  logic [63:0] sq_q;
  logic signed [48:0] v1p5_q, v1p2_q, v1p5b_q, v1p2b_q, pp6lo_q, pp3lo_q;
  logic [31:0] pp6hi_q, pp3hi_q;
  logic [63:0] v2_q, v1n_q, tsum_q, numa_q;
  logic [47:0] pptlo_q;
  logic [31:0] ppthi_q, ppnhi_q;
  logic [43:0] ppnlo_q;
  logic [63:0] dv_q, num_q, mn_q, md_q;
  logic neg_q, zero_q;

  logic [63:0] drem_q [NDiv];
  logic [63:0] dnq_q [NDiv];
  logic [63:0] dmd_q [NDiv];
  logic [NDiv-1:0] dneg_q, dzero_q;
  logic [NPost-1:0] pz_q;

  logic [63:0] p_q, p10_q, q13_q, p11_q, q13b_q, aq_q, w2_q, p12_q, w2b_q, ll_q, sum_q;
  logic signed [48:0] pp9lo_q, pp8lo_q;
  logic [31:0] pp9hi_q, pp8hi_q, lh_q, hl_q;

  logic signed [65:0] sqf_w;
  logic [63:0] s3_w, s3sh_w, t_w, dvsh_w, q13_w, p8s_w, w2sh_w, prod_w, w1_w;
  logic [20:0] diff_w;
  logic [31:0] p7s_w, pout_w;

  logic [63:0] src_rem [NDiv];
  logic [63:0] src_nq [NDiv];
  logic [63:0] src_md [NDiv];
  logic [63:0] nx_rem [NDiv];
  logic [63:0] nx_nq [NDiv];
  logic [64:0] shf, dif;

  // Output queue.
  btc_pkg::result_t oq_mem_q [btc_pkg::QDepth];
  logic [btc_pkg::QAw-1:0] owptr_q, orptr_q;
  logic [btc_pkg::QAw:0]   ocnt_q;
  logic oq_full, oq_push, oq_pop;
  btc_pkg::result_t res_w;

  assign oq_full = ocnt_q == (btc_pkg::QAw+1)'(btc_pkg::QDepth);
  assign empty_o = ocnt_q == '0;
  assign res_o   = oq_mem_q[orptr_q];
  assign adv     = !(qvld_q[NPost-1] && oq_full);
  assign oq_push = qvld_q[NPost-1] && adv;
  assign oq_pop  = pop_i && !empty_o;
  assign q_pop_o = adv && !q_empty_i;

  assign sqf_w  = v1_q * v1_q;
  assign s3_w   = {{15{pp3lo_q[48]}}, pp3lo_q} + {pp3hi_q, 32'd0};
  assign s3sh_w = $signed(s3_w) >>> 8;
  assign diff_w = btc_pkg::RawFull - {1'b0, pit_q[3].raw_pressure};
  assign t_w    = {16'd0, pptlo_q} + {ppthi_q, 32'd0};
  assign dvsh_w = $signed(t_w) >>> 33;
  assign q13_w  = $signed(p_q) >>> 13;
  assign p8s_w  = {{15{pp8lo_q[48]}}, pp8lo_q} + {pp8hi_q, 32'd0};
  assign w2sh_w = $signed(p8s_w) >>> 19;
  assign prod_w = ll_q + {lh_q + hl_q, 32'd0};
  assign w1_w   = $signed(prod_w) >>> 25;
  assign p7s_w  = {{12{cal_i.p7[15]}}, cal_i.p7, 4'd0};
  assign pout_w = sum_q[39:8] + p7s_w;

  assign res_w = '{pressure_pa: pz_q[NPost-1] ? 24'd0 : pout_w[31:8],
                   milli: qit_q[NPost-1].milli,
                   fine: qit_q[NPost-1].fine,
                   divisor_zero: pz_q[NPost-1]};

  // One restoring quotient bit per stage.
  always_comb begin
    src_rem[0] = '0;
    src_nq[0]  = mn_q;
    src_md[0]  = md_q;
    for (int k = 1; k < NDiv; k++) begin
      src_rem[k] = drem_q[k-1];
      src_nq[k]  = dnq_q[k-1];
      src_md[k]  = dmd_q[k-1];
    end
    shf = '0;
    dif = '0;
    for (int k = 0; k < NDiv; k++) begin
      shf = {src_rem[k], src_nq[k][63]};
      dif = shf - {1'b0, src_md[k]};
      nx_rem[k] = dif[64] ? shf[63:0] : dif[63:0];
      nx_nq[k]  = {src_nq[k][62:0], !dif[64]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pvld_q <= '0;
      dvld_q <= '0;
      qvld_q <= '0;
    end else if (adv) begin
      pvld_q <= {pvld_q[NPre-2:0], !q_empty_i};
      dvld_q <= {dvld_q[NDiv-2:0], pvld_q[NPre-1]};
      qvld_q <= {qvld_q[NPost-2:0], dvld_q[NDiv-1]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pit_q[0] <= q_item_i;
      for (int k = 1; k < NPre; k++) pit_q[k] <= pit_q[k-1];
      dit_q[0] <= pit_q[NPre-1];
      for (int k = 1; k < NDiv; k++) dit_q[k] <= dit_q[k-1];
      qit_q[0] <= dit_q[NDiv-1];
      for (int k = 1; k < NPost; k++) qit_q[k] <= qit_q[k-1];

      v1_q <= $signed({q_item_i.fine[31], q_item_i.fine}) -
              $signed({1'b0, btc_pkg::FineOffset});
      sq_q <= sqf_w[63:0];
      v1p5_q <= v1_q * $signed(cal_i.p5);
      v1p2_q <= v1_q * $signed(cal_i.p2);
      pp6lo_q <= $signed({1'b0, sq_q[31:0]}) * $signed(cal_i.p6);
      pp6hi_q <= sq_q[63:32] * {{16{cal_i.p6[15]}}, cal_i.p6};
      pp3lo_q <= $signed({1'b0, sq_q[31:0]}) * $signed(cal_i.p3);
      pp3hi_q <= sq_q[63:32] * {{16{cal_i.p3[15]}}, cal_i.p3};
      v1p5b_q <= v1p5_q;
      v1p2b_q <= v1p2_q;
      v2_q <= {{15{pp6lo_q[48]}}, pp6lo_q} + {pp6hi_q, 32'd0} +
              {v1p5b_q[46:0], 17'd0} + {{13{cal_i.p4[15]}}, cal_i.p4, 35'd0};
      v1n_q <= s3sh_w + {{3{v1p2b_q[48]}}, v1p2b_q, 12'd0};
      tsum_q <= btc_pkg::Q47One + v1n_q;
      numa_q <= {12'd0, diff_w, 31'd0} - v2_q;
      pptlo_q <= tsum_q[31:0] * cal_i.p1;
      ppthi_q <= tsum_q[63:32] * {16'd0, cal_i.p1};
      ppnlo_q <= numa_q[31:0] * btc_pkg::PressScale;
      ppnhi_q <= numa_q[63:32] * {20'd0, btc_pkg::PressScale};
      dv_q <= dvsh_w;
      num_q <= {20'd0, ppnlo_q} + {ppnhi_q, 32'd0};
      neg_q <= num_q[63] ^ dv_q[63];
      zero_q <= dv_q == '0;
      mn_q <= num_q[63] ? (64'd0 - num_q) : num_q;
      md_q <= dv_q[63] ? (64'd0 - dv_q) : dv_q;

      for (int k = 0; k < NDiv; k++) begin
        drem_q[k] <= nx_rem[k];
        dnq_q[k]  <= nx_nq[k];
        dmd_q[k]  <= src_md[k];
      end
      dneg_q  <= {dneg_q[NDiv-2:0], neg_q};
      dzero_q <= {dzero_q[NDiv-2:0], zero_q};
      pz_q    <= {pz_q[NPost-2:0], dzero_q[NDiv-1]};

      p_q <= dneg_q[NDiv-1] ? (64'd0 - dnq_q[NDiv-1]) : dnq_q[NDiv-1];
      p10_q <= p_q;
      q13_q <= q13_w;
      pp9lo_q <= $signed({1'b0, q13_w[31:0]}) * $signed(cal_i.p9);
      pp9hi_q <= q13_w[63:32] * {{16{cal_i.p9[15]}}, cal_i.p9};
      pp8lo_q <= $signed({1'b0, p_q[31:0]}) * $signed(cal_i.p8);
      pp8hi_q <= p_q[63:32] * {{16{cal_i.p8[15]}}, cal_i.p8};
      p11_q <= p10_q;
      q13b_q <= q13_q;
      aq_q <= {{15{pp9lo_q[48]}}, pp9lo_q} + {pp9hi_q, 32'd0};
      w2_q <= w2sh_w;
      p12_q <= p11_q;
      w2b_q <= w2_q;
      ll_q <= aq_q[31:0] * q13b_q[31:0];
      lh_q <= aq_q[31:0] * q13b_q[63:32];
      hl_q <= aq_q[63:32] * q13b_q[31:0];
      sum_q <= p12_q + w1_w + w2b_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owptr_q <= '0;
      orptr_q <= '0;
      ocnt_q  <= '0;
    end else begin
      if (oq_push) owptr_q <= owptr_q + 1'b1;
      if (oq_pop) orptr_q <= orptr_q + 1'b1;
      if (oq_push && !oq_pop) begin
        ocnt_q <= ocnt_q + 1'b1;
      end else if (oq_pop && !oq_push) begin
        ocnt_q <= ocnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (oq_push) oq_mem_q[owptr_q] <= res_w;
  end

endmodule

`default_nettype wire

/* hw/rtl/baro_temp_compensation.sv */
// Throughput: one transaction per cycle unless a full queue stalls the pipelines, set by
// the 7-stage temperature pipeline, the 13-stage pressure pipeline and its 64-stage divider,
// each stage taking a new item every cycle.
// Reset: asynchronous, active low; clears all valid bits, both queues and the calibration
// registers, which read back as zero.
`default_nettype none

module baro_temp_compensation (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready,
  input  logic               push,
  output logic               full,
  input  logic [19:0]        raw_pressure_i,
  input  logic [19:0]        raw_temperature_i,
  output logic               empty,
  input  logic               pop,
  output logic [23:0]        pressure_pa_o,
  output logic signed [31:0] temperature_milli_c_o,
  output logic signed [31:0] fine_temp_o,
  output logic               divisor_zero_o
);

  logic [47:0] temp_q;
  logic [63:0] plo_q, phi_q;
  logic [15:0] p9_q;
  btc_pkg::cfg_reg_e reg_sel;
  btc_pkg::temp_cal_t tcal;
  btc_pkg::press_cal_t pcal;

  logic mid_full, mid_push, mid_empty, mid_pop;
  btc_pkg::temp_res_t mid_in, mid_out;
  btc_pkg::result_t res;

  assign pready  = 1'b1;
  assign reg_sel = btc_pkg::cfg_reg_e'(paddr[4:3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_q <= '0;
      plo_q  <= '0;
      phi_q  <= '0;
      p9_q   <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        btc_pkg::CfgTemp:      temp_q <= pwdata[47:0];
        btc_pkg::CfgPressLo:   plo_q  <= pwdata;
        btc_pkg::CfgPressHi:   phi_q  <= pwdata;
        btc_pkg::CfgPressNine: p9_q   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      btc_pkg::CfgTemp:      prdata = {16'd0, temp_q};
      btc_pkg::CfgPressLo:   prdata = plo_q;
      btc_pkg::CfgPressHi:   prdata = phi_q;
      btc_pkg::CfgPressNine: prdata = {48'd0, p9_q};
      default:               prdata = '0;
    endcase
  end

  assign tcal = '{t1: temp_q[15:0], t2: temp_q[31:16], t3: temp_q[47:32]};
  assign pcal = '{p1: plo_q[15:0], p2: plo_q[31:16], p3: plo_q[47:32], p4: plo_q[63:48],
                  p5: phi_q[15:0], p6: phi_q[31:16], p7: phi_q[47:32], p8: phi_q[63:48],
                  p9: p9_q};

  btc_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cal_i             (tcal),
    .in_push_i         (push),
    .in_full_o         (full),
    .raw_pressure_i    (raw_pressure_i),
    .raw_temperature_i (raw_temperature_i),
    .q_full_i          (mid_full),
    .q_push_o          (mid_push),
    .q_item_o          (mid_in)
  );

  btc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mid_push),
    .full_o  (mid_full),
    .item_i  (mid_in),
    .pop_i   (mid_pop),
    .empty_o (mid_empty),
    .item_o  (mid_out)
  );

  btc_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cal_i     (pcal),
    .q_empty_i (mid_empty),
    .q_item_i  (mid_out),
    .q_pop_o   (mid_pop),
    .empty_o   (empty),
    .pop_i     (pop),
    .res_o     (res)
  );

  assign pressure_pa_o         = res.pressure_pa;
  assign temperature_milli_c_o = $signed(res.milli);
  assign fine_temp_o           = $signed(res.fine);
  assign divisor_zero_o        = res.divisor_zero;

endmodule

`default_nettype wire

/* tb/baro_temp_compensation_test.sv */
module baro_temp_compensation_test;

  typedef struct {
    logic [19:0] raw_p;
    logic [19:0] raw_t;
  } sample_t;

  typedef struct {
    logic [23:0] pa;
    logic [31:0] milli;
    logic [31:0] fine;
    logic        dz;
  } reading_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;
  logic        push = 1'b0;
  logic        full;
  logic [19:0] raw_pressure_i = '0;
  logic [19:0] raw_temperature_i = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [23:0] pressure_pa_o;
  logic signed [31:0] temperature_milli_c_o;
  logic signed [31:0] fine_temp_o;
  logic        divisor_zero_o;

  baro_temp_compensation dut (.*);

  logic [47:0] cal_temp;
  logic [63:0] cal_lo, cal_hi;
  logic [15:0] cal_nine;

  sample_t  pending_samples[$];
  reading_t expected_readings[$];
  int       errors = 0;
  int       cycles = 0;
  int       push_gap = 0;
  int       pop_gap = 0;
  int       hold_off = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [63:0] sdiv(logic [63:0] n, logic [63:0] d);
    logic [63:0] mn, md, q;
    mn = n[63] ? -n : n;
    md = d[63] ? -d : d;
    q = mn / md;
    return (n[63] != d[63]) ? -q : q;
  endfunction

  function automatic reading_t compensate(sample_t s);
    reading_t r;
    logic signed [31:0] t1, t2, t3, a, d, tv1, tv2, fine, hund, m;
    logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, v1, v2, p, q, w1, w2;
    t1 = {16'd0, cal_temp[15:0]};
    t2 = {{16{cal_temp[31]}}, cal_temp[31:16]};
    t3 = {{16{cal_temp[47]}}, cal_temp[47:32]};
    p1 = {48'd0, cal_lo[15:0]};
    p2 = {{48{cal_lo[31]}}, cal_lo[31:16]};
    p3 = {{48{cal_lo[47]}}, cal_lo[47:32]};
    p4 = {{48{cal_lo[63]}}, cal_lo[63:48]};
    p5 = {{48{cal_hi[15]}}, cal_hi[15:0]};
    p6 = {{48{cal_hi[31]}}, cal_hi[31:16]};
    p7 = {{48{cal_hi[47]}}, cal_hi[47:32]};
    p8 = {{48{cal_hi[63]}}, cal_hi[63:48]};
    p9 = {{48{cal_nine[15]}}, cal_nine};
    a = {12'd0, s.raw_t} >>> 3;
    a = a - (t1 << 1);
    tv1 = (a * t2) >>> 11;
    d = ({12'd0, s.raw_t} >>> 4) - t1;
    tv2 = (((d * d) >>> 12) * t3) >>> 14;
    fine = tv1 + tv2;
    hund = (fine * 32'sd5 + 32'sd128) >>> 8;
    m = hund * 32'sd1000;
    r.milli = m[31] ? -(32'(-m) / 32'd100) : 32'(m) / 32'd100;
    r.fine = fine;
    v1 = 64'(fine) - 64'sd128000;
    v2 = v1 * v1 * p6;
    v2 = v2 + ((v1 * p5) <<< 17);
    v2 = v2 + (p4 <<< 35);
    v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) <<< 12);
    v1 = (((64'sd1 <<< 47) + v1) * p1) >>> 33;
    r.pa = '0;
    r.dz = (v1 == 0);
    if (!r.dz) begin
      p = 64'sd1048576 - {44'd0, s.raw_p};
      p = ((p <<< 31) - v2) * 64'sd3125;
      p = sdiv(p, v1);
      q = p >>> 13;
      w1 = (p9 * q * q) >>> 25;
      w2 = (p8 * p) >>> 19;
      p = ((p + w1 + w2) >>> 8) + (p7 <<< 4);
      r.pa = p[31:8];
    end
    return r;
  endfunction

  task automatic write_reg(btc_pkg::cfg_reg_e idx, logic [63:0] val);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= 5'(idx) << 3; pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      btc_pkg::CfgTemp:      cal_temp = val[47:0];
      btc_pkg::CfgPressLo:   cal_lo = val;
      btc_pkg::CfgPressHi:   cal_hi = val;
      btc_pkg::CfgPressNine: cal_nine = val[15:0];
    endcase
  endtask

  task automatic wait_idle();
    while (pending_samples.size() != 0 || expected_readings.size() != 0)
      @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  function automatic logic [19:0] rand_raw();
    case ($urandom_range(0, 5))
      0: return 20'd0;
      1: return 20'hFFFFF;
      2: return 20'($urandom_range(300000, 700000));
      default: return 20'($urandom);
    endcase
  endfunction

  task automatic enqueue(logic [19:0] rp, logic [19:0] rt);
    sample_t s;
    s.raw_p = rp;
    s.raw_t = rt;
    pending_samples.push_back(s);
  endtask

  task automatic load_cal(int kind);
    logic [63:0] lo, hi;
    case (kind)
      0: begin
        // Typical factory calibration words.
        write_reg(btc_pkg::CfgTemp, {16'hFC18, 16'd26435, 16'd27504});
        write_reg(btc_pkg::CfgPressLo, {16'd2855, 16'h0BB8, 16'hD4DA, 16'd36477});
        write_reg(btc_pkg::CfgPressHi, {16'hE893, 16'd15500, 16'hFFF9, 16'd140});
        write_reg(btc_pkg::CfgPressNine, 64'd6000);
      end
      1: begin
        write_reg(btc_pkg::CfgTemp, 64'hFFFF_FFFF_FFFF);
        write_reg(btc_pkg::CfgPressLo, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(btc_pkg::CfgPressHi, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(btc_pkg::CfgPressNine, 64'hFFFF);
      end
      2: begin
        write_reg(btc_pkg::CfgTemp, 64'h8000_8000_0000);
        write_reg(btc_pkg::CfgPressLo, 64'h8000_8000_8000_0000);
        write_reg(btc_pkg::CfgPressHi, 64'h8000_8000_8000_8000);
        write_reg(btc_pkg::CfgPressNine, 64'h8000);
      end
      default: begin
        write_reg(btc_pkg::CfgTemp, {$urandom, $urandom});
        lo = {$urandom, $urandom};
        // P1 of zero forces the zero-divisor path now and then.
        if ($urandom_range(0, 3) == 0) lo[15:0] = '0;
        hi = {$urandom, $urandom};
        write_reg(btc_pkg::CfgPressLo, lo);
        write_reg(btc_pkg::CfgPressHi, hi);
        write_reg(btc_pkg::CfgPressNine, 64'($urandom));
      end
    endcase
  endtask

  // An input transaction is taken at the rising edge; predict it right there.
  always @(posedge clk_i) begin
    if (rst_ni && push && !full) begin
      expected_readings.push_back(compensate(pending_samples.pop_front()));
      push_gap = $urandom_range(0, 13);
      if ($urandom_range(0, 3) == 0) push_gap = 0;
    end
  end

  // Driver: offers the queue head after a random gap.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (push_gap > 0) begin
        push_gap--;
        push <= 1'b0;
      end else if (pending_samples.size() != 0) begin
        push <= 1'b1;
        raw_pressure_i <= pending_samples[0].raw_p;
        raw_temperature_i <= pending_samples[0].raw_t;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Monitor: checks each popped result against the oldest prediction.
  always @(posedge clk_i) begin
    reading_t e;
    cycles++;
    if (pop && !empty) begin
      if (expected_readings.size() == 0) begin
        $display("%0t: unexpected result pa=%0d", $time, pressure_pa_o);
        errors++;
      end else begin
        e = expected_readings.pop_front();
        if (pressure_pa_o !== e.pa) begin
          $display("%0t: pressure_pa expected %0d actual %0d", $time, e.pa, pressure_pa_o);
          errors++;
        end
        if (temperature_milli_c_o !== e.milli) begin
          $display("%0t: temperature_milli_c expected %0d actual %0d", $time,
                   $signed(e.milli), temperature_milli_c_o);
          errors++;
        end
        if (fine_temp_o !== e.fine) begin
          $display("%0t: fine_temp expected %0d actual %0d", $time, $signed(e.fine),
                   fine_temp_o);
          errors++;
        end
        if (divisor_zero_o !== e.dz) begin
          $display("%0t: divisor_zero expected %0b actual %0b", $time, e.dz, divisor_zero_o);
          errors++;
        end
      end
      pop_gap = $urandom_range(0, 13);
      if ($urandom_range(0, 3) == 0) pop_gap = 0;
    end
    if (cycles > 400000) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off--;
      pop <= 1'b0;
    end else if (pop_gap > 0) begin
      pop_gap--;
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  initial begin
    cal_temp = '0; cal_lo = '0; cal_hi = '0; cal_nine = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    // All coefficients zero after reset: divisor is zero.
    enqueue(20'd0, 20'd0);
    enqueue(20'hFFFFF, 20'hFFFFF);
    wait_idle();
    load_cal(0);
    enqueue(20'd0, 20'd0);
    enqueue(20'hFFFFF, 20'hFFFFF);
    enqueue(20'd0, 20'hFFFFF);
    enqueue(20'hFFFFF, 20'd0);
    enqueue(20'd415148, 20'd519888);
    enqueue(20'h80000, 20'h80000);
    enqueue(20'h55555, 20'hAAAAA);
    enqueue(20'hAAAAA, 20'h55555);
    wait_idle();
    load_cal(1);
    enqueue(20'd0, 20'd0);
    enqueue(20'hFFFFF, 20'hFFFFF);
    enqueue(20'h55555, 20'hAAAAA);
    wait_idle();
    load_cal(2);
    enqueue(20'd0, 20'hFFFFF);
    enqueue(20'hFFFFF, 20'd0);
    enqueue(20'hAAAAA, 20'h55555);
    wait_idle();
    // The receiver stalls long so the block fills and pushes back.
    load_cal(0);
    hold_off = 1500;
    for (int i = 0; i < 150; i++) enqueue(rand_raw(), rand_raw());
    wait_idle();
    for (int ph = 0; ph < 10; ph++) begin
      load_cal(ph < 2 ? 0 : 3);
      for (int i = 0; i < 60; i++) enqueue(rand_raw(), rand_raw());
      wait_idle();
    end
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
